// ----- hdl/rcsfd_pkg.sv -----
// ----------------------------------------------------------------------------
// rcsfd_pkg
// Shared types and constants of the serial RC frame decoder.
// ----------------------------------------------------------------------------
package rcsfd_pkg;

	localparam int STORE_DEPTH  = 16;
	localparam int STORE_AW     = 4;
	localparam int WORDS        = 7;
	localparam int DATA_BYTES   = 2 * WORDS;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QUEUE_AW     = 1;
	localparam int VALUE_W      = 11;
	localparam int SERVO_W      = 16;
	localparam int NUM_CHANNELS = 16;
	localparam int CHAN_W       = $clog2(NUM_CHANNELS);

	localparam logic [1:0] REG_HDR0       = 2'd0;
	localparam logic [1:0] REG_HDR1       = 2'd1;
	localparam logic [1:0] REG_SERVO_BASE = 2'd2;

	localparam logic [7:0]  HDR0_RST       = 8'h00;
	localparam logic [7:0]  HDR1_RST       = 8'hB2;
	localparam logic [15:0] SERVO_BASE_RST = 16'd2000;

	// one closed frame as handed from front to back
	typedef struct packed {
		logic                            ok;
		logic [DATA_BYTES-1:0][7:0]      data;
	} frame_t;

endpackage

// ----- hdl/rcsfd_front.sv -----
// ----------------------------------------------------------------------------
// rcsfd_front
// Collects bytes into frames, checks the header and queues closed frames.
// ----------------------------------------------------------------------------
module rcsfd_front #(
	parameter int FRAME_BYTES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           hdr0,
	input  logic [7:0]           hdr1,
	input  logic                 q_full,
	output logic                 q_push,
	output rcsfd_pkg::frame_t    q_wdata
);

	localparam int CNT_W = $clog2(FRAME_BYTES);
	localparam int EXT_W = (CNT_W > rcsfd_pkg::STORE_AW) ? CNT_W : rcsfd_pkg::STORE_AW + 1;

	logic [CNT_W-1:0] byte_cnt_q;
	logic [7:0]       store_q [rcsfd_pkg::STORE_DEPTH];
	logic [7:0]       store_nxt [rcsfd_pkg::STORE_DEPTH];
	logic [EXT_W-1:0] cnt_ext;
	logic             store_we;
	logic             is_last;
	logic             accept;

	assign cnt_ext  = EXT_W'(byte_cnt_q);
	assign store_we = cnt_ext < EXT_W'(rcsfd_pkg::STORE_DEPTH);
	assign is_last  = byte_cnt_q == CNT_W'(FRAME_BYTES - 1);
	assign in_ready = !is_last || !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && is_last;

	always_comb begin
		for (int i = 0; i < rcsfd_pkg::STORE_DEPTH; i++) begin
			store_nxt[i] = store_q[i];
		end
		if (store_we) begin
			store_nxt[cnt_ext[rcsfd_pkg::STORE_AW-1:0]] = rx_byte;
		end
	end

	always_comb begin
		q_wdata.ok = (store_nxt[0] == hdr0) && (store_nxt[1] == hdr1);
		for (int i = 0; i < rcsfd_pkg::DATA_BYTES; i++) begin
			q_wdata.data[i] = store_nxt[i + 2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
		end else if (accept) begin
			byte_cnt_q <= is_last ? '0 : byte_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && store_we) begin
			store_q[cnt_ext[rcsfd_pkg::STORE_AW-1:0]] <= rx_byte;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_cnt_q <= CNT_W'(FRAME_BYTES - 1))
		else $error("byte count out of range");
	a_push_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> byte_cnt_q == '0)
		else $error("count not cleared after frame");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("frame pushed into full queue");

endmodule

// ----- hdl/rcsfd_fifo.sv -----
// ----------------------------------------------------------------------------
// rcsfd_fifo
// Short frame queue decoupling the byte front from the word back.
// ----------------------------------------------------------------------------
module rcsfd_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rcsfd_pkg::frame_t    wdata,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output rcsfd_pkg::frame_t    rdata
);

	localparam int AW = rcsfd_pkg::QUEUE_AW;

	rcsfd_pkg::frame_t mem_q [rcsfd_pkg::QUEUE_DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [AW:0]       count_q;

	assign full      = count_q == (AW+1)'(rcsfd_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(rcsfd_pkg::QUEUE_DEPTH))
		else $error("queue count overflow");
	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("pointers disagree with empty count");

endmodule

// ----- hdl/rcsfd_back.sv -----
// ----------------------------------------------------------------------------
// rcsfd_back
// Takes queued frames, updates channel 0 and emits seven word results.
// ----------------------------------------------------------------------------
module rcsfd_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [15:0]                       servo_base,
	input  logic                              q_not_empty,
	input  rcsfd_pkg::frame_t                 q_rdata,
	output logic                              q_pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              frame_ok,
	output logic [2:0]                        word_index,
	output logic                              word_valid,
	output logic [rcsfd_pkg::CHAN_W-1:0]      channel,
	output logic [rcsfd_pkg::VALUE_W-1:0]     value,
	output logic [rcsfd_pkg::SERVO_W-1:0]     servo_compare,
	output logic                              last
);

	rcsfd_pkg::frame_t             frame_q;
	logic                          busy_q;
	logic [2:0]                    idx_q;
	logic [rcsfd_pkg::VALUE_W-1:0] ch0_q;
	logic [rcsfd_pkg::VALUE_W-1:0] ch0_nxt;
	logic [rcsfd_pkg::SERVO_W-1:0] servo_q;
	logic                          out_valid_q;
	logic                          emit;
	logic [2:0]                    word_sel;
	logic [7:0]                    hi;
	logic [7:0]                    lo;

	assign q_pop    = !busy_q && q_not_empty;
	assign emit     = busy_q && (!out_valid_q || out_ready);
	assign word_sel = idx_q - 3'd1;
	assign hi       = frame_q.data[{word_sel, 1'b0}];
	assign lo       = frame_q.data[{word_sel, 1'b1}];
	assign out_valid = out_valid_q;

	// final channel 0 value after the incoming frame, later words win
	always_comb begin
		ch0_nxt = ch0_q;
		for (int k = 0; k < rcsfd_pkg::WORDS; k++) begin
			if (q_rdata.ok && !q_rdata.data[2*k][7] && q_rdata.data[2*k][6:3] == 4'd0) begin
				ch0_nxt = {q_rdata.data[2*k][2:0], q_rdata.data[2*k+1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= 3'd1;
			ch0_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q  <= 3'd1;
				ch0_q  <= ch0_nxt;
			end else if (emit) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'(rcsfd_pkg::WORDS)) begin
					busy_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			frame_q <= q_rdata;
			servo_q <= servo_base + rcsfd_pkg::SERVO_W'(ch0_nxt);
		end
		if (emit) begin
			frame_ok      <= frame_q.ok;
			word_index    <= idx_q;
			word_valid    <= frame_q.ok && !hi[7];
			channel       <= hi[6:3];
			value         <= {hi[2:0], lo};
			servo_compare <= servo_q;
			last          <= idx_q == 3'(rcsfd_pkg::WORDS);
		end
	end

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q >= 3'd1 && idx_q <= 3'(rcsfd_pkg::WORDS)))
		else $error("word index out of range");
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (last == (word_index == 3'(rcsfd_pkg::WORDS))))
		else $error("last flag disagrees with word index");
	a_valid_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && word_valid) |-> frame_ok)
		else $error("word valid in rejected frame");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q && $stable(word_index))
		else $error("result changed while stalled");

endmodule

// ----- hdl/rc_serial_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// rc_serial_frame_decoder
// Serial RC frame decoder: bytes in, seven decoded word results per frame.
// ----------------------------------------------------------------------------
//  channel   signals                         dir   moves
//  in        in_valid/in_ready, rx_byte      in    one received byte
//  out       out_valid/out_ready, 7 fields   out   one decoded word
//  cfg       cfg_we, cfg_index, cfg_wdata    in    register write, no wait
//
//  The closing byte of a frame is pushed to a two-entry frame queue. The
//  back unit pops a frame when idle and then emits one word per cycle while
//  out_ready allows, seven per frame. The front stalls only on a closing
//  byte with the queue full; the back stalls on out_ready. Reset clears
//  counters, queue, channel 0 value and loads register defaults; no
//  clearing pass.
// ----------------------------------------------------------------------------
module rc_serial_frame_decoder #(
	parameter int FRAME_BYTES  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        rx_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              frame_ok,
	output logic [2:0]                        word_index,
	output logic                              word_valid,
	output logic [rcsfd_pkg::CHAN_W-1:0]      channel,
	output logic [rcsfd_pkg::VALUE_W-1:0]     value,
	output logic [rcsfd_pkg::SERVO_W-1:0]     servo_compare,
	output logic                              last,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [15:0]                       cfg_wdata
);

	logic [7:0]        hdr0_q;
	logic [7:0]        hdr1_q;
	logic [15:0]       servo_base_q;
	logic              q_full;
	logic              q_push;
	logic              q_pop;
	logic              q_not_empty;
	rcsfd_pkg::frame_t q_wdata;
	rcsfd_pkg::frame_t q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr0_q       <= rcsfd_pkg::HDR0_RST;
			hdr1_q       <= rcsfd_pkg::HDR1_RST;
			servo_base_q <= rcsfd_pkg::SERVO_BASE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rcsfd_pkg::REG_HDR0:       hdr0_q       <= cfg_wdata[7:0];
				rcsfd_pkg::REG_HDR1:       hdr1_q       <= cfg_wdata[7:0];
				rcsfd_pkg::REG_SERVO_BASE: servo_base_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	rcsfd_front #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.hdr0     (hdr0_q),
		.hdr1     (hdr1_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	rcsfd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rdata     (q_rdata)
	);

	rcsfd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.servo_base    (servo_base_q),
		.q_not_empty   (q_not_empty),
		.q_rdata       (q_rdata),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.frame_ok      (frame_ok),
		.word_index    (word_index),
		.word_valid    (word_valid),
		.channel       (channel),
		.value         (value),
		.servo_compare (servo_compare),
		.last          (last)
	);

endmodule

// ----- tb/rc_serial_frame_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// rc_serial_frame_decoder_tb
// Self-checking bench: feeds received bytes in random bursts, predicts the
// seven decoded words of each 16-byte frame and checks every output
// transaction in order, across several header and servo base settings.
// ----------------------------------------------------------------------------
module rc_serial_frame_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_LEN   = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 20;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic        ok;
		logic [2:0]  idx;
		logic        wvalid;
		logic [3:0]  chan;
		logic [10:0] val;
		logic [15:0] servo;
		logic        lst;
	} word_t;

	typedef enum int {FR_GOOD, FR_BAD_HDR0, FR_BAD_HDR1, FR_JUNK} frame_kind_t;

	class frame_scoreboard;
		logic [7:0]  hdr0;
		logic [7:0]  hdr1;
		logic [15:0] base;
		logic [3:0]  byte_cnt;
		logic [7:0]  store [FRAME_LEN];
		logic [10:0] chan_tbl [16];
		word_t       exp_q [$];
		int          errors, bytes_in, frames, frames_ok, words_valid, words_checked;

		function new();
			hdr0 = rcsfd_pkg::HDR0_RST;
			hdr1 = rcsfd_pkg::HDR1_RST;
			base = rcsfd_pkg::SERVO_BASE_RST;
			byte_cnt = '0;
			foreach (store[i]) store[i] = '0;
			foreach (chan_tbl[i]) chan_tbl[i] = '0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] d);
			case (idx)
				rcsfd_pkg::REG_HDR0:       hdr0 = d[7:0];
				rcsfd_pkg::REG_HDR1:       hdr1 = d[7:0];
				rcsfd_pkg::REG_SERVO_BASE: base = d;
				default: ;
			endcase
		endfunction

		function int pending();
			return exp_q.size();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("MISMATCH @%0t: %s", $time, msg);
		endtask

		// accepted byte; a closing byte yields seven words
		function void note_byte(logic [7:0] b);
			word_t       w [7];
			logic        ok;
			logic [7:0]  hi, lo;
			logic [15:0] servo;
			bytes_in++;
			store[byte_cnt] = b;
			if (byte_cnt != 4'(FRAME_LEN - 1)) begin
				byte_cnt++;
				return;
			end
			byte_cnt = '0;
			frames++;
			ok = (store[0] == hdr0) && (store[1] == hdr1);
			if (ok)
				frames_ok++;
			for (int k = 1; k <= 7; k++) begin
				hi = store[2 * k];
				lo = store[2 * k + 1];
				w[k-1].ok     = ok;
				w[k-1].idx    = 3'(k);
				w[k-1].wvalid = ok && !hi[7];
				w[k-1].chan   = hi[6:3];
				w[k-1].val    = {hi[2:0], lo};
				w[k-1].lst    = (k == 7);
				if (w[k-1].wvalid) begin
					chan_tbl[hi[6:3]] = {hi[2:0], lo};
					words_valid++;
				end
			end
			servo = base + 16'(chan_tbl[0]);
			for (int k = 0; k < 7; k++) begin
				w[k].servo = servo;
				exp_q.push_back(w[k]);
			end
		endfunction

		task check_word(word_t got);
			word_t e;
			words_checked++;
			if (exp_q.size() == 0) begin
				report($sformatf("unexpected word %p", got));
				return;
			end
			e = exp_q.pop_front();
			if (got.ok !== e.ok)
				report($sformatf("frame_ok got %0b exp %0b", got.ok, e.ok));
			if (got.idx !== e.idx)
				report($sformatf("word_index got %0d exp %0d", got.idx, e.idx));
			if (got.wvalid !== e.wvalid)
				report($sformatf("word_valid got %0b exp %0b", got.wvalid, e.wvalid));
			if (got.chan !== e.chan)
				report($sformatf("channel got %0d exp %0d", got.chan, e.chan));
			if (got.val !== e.val)
				report($sformatf("value got %0d exp %0d", got.val, e.val));
			if (got.servo !== e.servo)
				report($sformatf("servo_compare got %0d exp %0d", got.servo, e.servo));
			if (got.lst !== e.lst)
				report($sformatf("last got %0b exp %0b", got.lst, e.lst));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic        frame_ok;
	logic [2:0]  word_index;
	logic        word_valid;
	logic [3:0]  channel;
	logic [10:0] value;
	logic [15:0] servo_compare;
	logic        last;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;

	frame_scoreboard sb;
	int unsigned     cycle_count;
	int              burst_left;
	int              settings_used;

	rc_serial_frame_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.frame_ok      (frame_ok),
		.word_index    (word_index),
		.word_valid    (word_valid),
		.channel       (channel),
		.value         (value),
		.servo_compare (servo_compare),
		.last          (last),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial cycle_count = 0;
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d words outstanding", cycle_count, sb.pending());
		$display("RESULT: ERROR");
		$finish;
	end

	// receiver: rotating stall patterns plus one long hold-off
	int rx_mode, rx_tick, hold_left;
	bit hold_done;

	always @(posedge clk) begin : rx_side
		word_t got;
		logic  rdy;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = {frame_ok, word_index, word_valid, channel, value, servo_compare, last};
				sb.check_word(got);
			end
			rx_tick++;
			if (rx_tick % 64 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0:       rdy = 1'b1;
				1:       rdy = 1'($urandom_range(0, 1));
				2:       rdy = (rx_tick % 5) < 3;
				default: rdy = ($urandom_range(0, 3) == 0);
			endcase
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (!hold_done && sb.words_checked >= 14) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				rdy = 1'b0;
			end
			out_ready <= rdy;
		end else begin
			out_ready <= 1'b0;
		end
	end

	task program_regs(logic [7:0] h0, logic [7:0] h1, logic [15:0] b);
		cfg_we    <= 1'b1;
		cfg_index <= rcsfd_pkg::REG_HDR0;
		cfg_wdata <= {8'h00, h0};
		@(posedge clk);
		cfg_index <= rcsfd_pkg::REG_HDR1;
		cfg_wdata <= {8'h00, h1};
		@(posedge clk);
		cfg_index <= rcsfd_pkg::REG_SERVO_BASE;
		cfg_wdata <= b;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(rcsfd_pkg::REG_HDR0, {8'h00, h0});
		sb.set_reg(rcsfd_pkg::REG_HDR1, {8'h00, h1});
		sb.set_reg(rcsfd_pkg::REG_SERVO_BASE, b);
		settings_used++;
	endtask

	task send_byte(logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_byte(b);
	endtask

	task send_frame(frame_kind_t kind);
		logic [7:0] fr [FRAME_LEN];
		logic [7:0] hi, lo;
		fr[0] = sb.hdr0;
		fr[1] = sb.hdr1;
		case (kind)
			FR_BAD_HDR0: fr[0] = sb.hdr0 ^ 8'($urandom_range(1, 255));
			FR_BAD_HDR1: fr[1] = sb.hdr1 ^ 8'($urandom_range(1, 255));
			FR_JUNK: begin
				fr[0] = 8'($urandom);
				fr[1] = 8'($urandom);
			end
			default: ;
		endcase
		for (int k = 1; k <= 7; k++) begin
			hi = 8'($urandom);
			lo = 8'($urandom);
			if ($urandom_range(0, 3) == 0)
				hi[6:3] = 4'd0;
			if ($urandom_range(0, 7) == 0)
				lo = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			fr[2 * k]     = hi;
			fr[2 * k + 1] = lo;
		end
		foreach (fr[i]) send_byte(fr[i]);
	endtask

	task wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin : main
		logic [7:0] directed [FRAME_LEN];
		int         r;
		sb = new();
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		rx_byte   <= 8'h00;
		cfg_we    <= 1'b0;
		cfg_index <= rcsfd_pkg::REG_HDR0;
		cfg_wdata <= 16'h0000;
		rx_mode = 0;
		rx_tick = 0;
		hold_left = 0;
		hold_done = 1'b0;
		burst_left = 0;
		settings_used = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frame: extremes, bit-7 words, repeated channels, channel 0 rewrite
		program_regs(rcsfd_pkg::HDR0_RST, rcsfd_pkg::HDR1_RST, rcsfd_pkg::SERVO_BASE_RST);
		directed = '{rcsfd_pkg::HDR0_RST, rcsfd_pkg::HDR1_RST,
			8'h07, 8'hFF,   // ch 0, 2047
			8'h78, 8'h00,   // ch 15, 0
			8'hFF, 8'hFF,   // bit 7 set
			8'h80, 8'h00,   // bit 7 set on ch 0
			8'h7F, 8'hFF,   // ch 15 again
			8'h01, 8'h23,   // ch 0 again
			8'h55, 8'hAA};
		foreach (directed[i]) send_byte(directed[i]);

		for (int phase = 0; phase < 4; phase++) begin
			wait_idle();
			case (phase)
				0:       program_regs(8'hFF, 8'h00, 16'd63488);
				1:       program_regs(8'($urandom), 8'($urandom), 16'd0);
				2:       program_regs(8'($urandom), 8'($urandom), 16'($urandom_range(0, 63488)));
				default: program_regs(rcsfd_pkg::HDR0_RST, rcsfd_pkg::HDR1_RST,
					rcsfd_pkg::SERVO_BASE_RST);
			endcase
			repeat (5) begin
				r = $urandom_range(0, 9);
				send_frame(r < 7 ? FR_GOOD : r == 7 ? FR_BAD_HDR0 : r == 8 ? FR_BAD_HDR1 : FR_JUNK);
			end
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d bytes, %0d frames (%0d with good headers), %0d words checked",
			sb.bytes_in, sb.frames, sb.frames_ok, sb.words_checked);
		$display("%0d channel table writes over %0d register settings, %0d mismatches",
			sb.words_valid, settings_used, sb.errors);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
